/* rtl/core/jpeg_marker_length_scanner_macros.svh */
// ----------------------------------------------------------------------------
// JPEG marker length scanner assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_LENGTH_SCANNER_MACROS_SVH
`define JPEG_MARKER_LENGTH_SCANNER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define JMLS_ASSERT_SAME(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define JMLS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/jmls_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner package
// Marker codes, status codes, scanner phases and register map constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jmls_pkg;

    localparam logic [7:0]  MK_PREFIX = 8'hFF;
    localparam logic [7:0]  MK_SOI    = 8'hD8;
    localparam logic [7:0]  MK_EOI    = 8'hD9;
    localparam logic [7:0]  MK_SOS    = 8'hDA;
    localparam logic [7:0]  MK_RST_LO = 8'hD0;
    localparam logic [7:0]  MK_RST_HI = 8'hD7;
    localparam logic [7:0]  MK_STUFF  = 8'h00;

    localparam logic [31:0] BYTE_LIMIT_RESET = 32'd67108864;

    localparam int          APB_ADDR_W     = 3;
    localparam logic [0:0]  REG_BYTE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        STATUS_EOI    = 2'd0,
        STATUS_NOSOI  = 2'd1,
        STATUS_BADLEN = 2'd2,
        STATUS_LIMIT  = 2'd3
    } status_t;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_SOI2    = 10'b00_0000_0010,
        PH_SCAN    = 10'b00_0000_0100,
        PH_MARK    = 10'b00_0000_1000,
        PH_LENHI   = 10'b00_0001_0000,
        PH_LENLO   = 10'b00_0010_0000,
        PH_SKIP    = 10'b00_0100_0000,
        PH_ENT     = 10'b00_1000_0000,
        PH_ENTMARK = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } phase_t;

endpackage

`default_nettype wire

/* rtl/core/jmls_byte_if.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner byte channel
// Carries one stream byte and its start flag per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jmls_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);

endinterface

`default_nettype wire

/* rtl/core/jmls_result_if.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner result channel
// Carries the scan status and the stream length per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jmls_result_if;

    logic              valid;
    logic              ready;
    jmls_pkg::status_t status;
    logic [31:0]       total_length;

    modport source (output valid, output status, output total_length, input ready);
    modport sink   (input valid, input status, input total_length, output ready);

endinterface

`default_nettype wire

/* rtl/core/jpeg_marker_length_scanner.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner
// Walks a JPEG byte stream and reports its length through the EOI marker.
// ----------------------------------------------------------------------------
// The stream channel takes one byte per request; start_req marks byte 0 of a
// new buffer and abandons any scan in progress. Bytes arriving while idle or
// after a scan has finished, without start_req, are dropped silently.
// Each scan produces at most one request on the report channel: the status
// and, for a found EOI, the byte count through the EOI marker.
// Throughput, set by the single phase register update, is one byte per cycle
// while the stream is not held off. Each report is registered in the output
// register; a second register behind it absorbs one further report while the
// receiver stalls, and the stream channel is held off only while it is full.
// The byte limit register (APB address 0) bounds the bytes scanned per buffer.
// Reset (rst_n low, asynchronous) returns the scanner to idle, empties both
// report registers and sets the byte limit to 64 MiB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "jpeg_marker_length_scanner_macros.svh"

module jpeg_marker_length_scanner (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [jmls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    jmls_byte_if.sink                            stream,
    jmls_result_if.source                        report
);

    import jmls_pkg::*;

    logic [31:0] byte_limit_reg;
    phase_t      phase_reg,       phase_next;
    logic [31:0] byte_pos_reg,    byte_pos_next;
    logic [15:0] skip_reg,        skip_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [7:0]  marker_reg,      marker_next;
    logic        in_entropy_reg,  in_entropy_next;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_length_reg;
    logic        skid_valid_reg;
    status_t     skid_status_reg;
    logic [31:0] skid_length_reg;

    logic        accept;
    logic        cfg_write;
    logic [31:0] pos_inc;
    logic [15:0] seg_len;
    logic        is_rst;
    logic        check_limit;
    logic        res_valid;
    status_t     res_status;
    logic [31:0] res_length;
    logic        out_taken;
    logic        report_stall;
    logic        out_failed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_BYTE_LIMIT) ? byte_limit_reg : 32'd0;

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && !skid_valid_reg;

    assign pos_inc = byte_pos_reg + 32'd1;
    assign seg_len = {length_high_reg, stream.data_byte};
    assign is_rst  = (stream.data_byte >= MK_RST_LO) && (stream.data_byte <= MK_RST_HI);

    always_comb
    begin
        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        skip_next        = skip_reg;
        length_high_next = length_high_reg;
        marker_next      = marker_reg;
        in_entropy_next  = in_entropy_reg;
        check_limit      = 1'b0;
        res_valid        = 1'b0;
        res_status       = STATUS_EOI;
        res_length       = 32'd0;

        if (accept)
        begin
            if (stream.start_req)
            begin
                byte_pos_next    = 32'd1;
                skip_next        = 16'd0;
                length_high_next = 8'd0;
                marker_next      = 8'd0;
                in_entropy_next  = 1'b0;
                if (stream.data_byte != MK_PREFIX)
                begin
                    res_valid  = 1'b1;
                    res_status = STATUS_NOSOI;
                end
                else
                begin
                    phase_next = PH_SOI2;
                    if (byte_limit_reg <= 32'd1)
                    begin
                        res_valid  = 1'b1;
                        res_status = STATUS_LIMIT;
                    end
                end
            end
            else if ((phase_reg != PH_IDLE) && (phase_reg != PH_DONE))
            begin
                byte_pos_next = pos_inc;
                check_limit   = 1'b1;
                case (phase_reg)
                    PH_SOI2:
                    begin
                        if (stream.data_byte != MK_SOI)
                        begin
                            res_valid   = 1'b1;
                            res_status  = STATUS_NOSOI;
                            check_limit = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_SCAN;
                        end
                    end
                    PH_SCAN:
                    begin
                        if (stream.data_byte == MK_PREFIX)
                        begin
                            phase_next = PH_MARK;
                        end
                    end
                    PH_MARK:
                    begin
                        if (stream.data_byte == MK_PREFIX)
                        begin
                            phase_next = PH_MARK;
                        end
                        else if (stream.data_byte == MK_EOI)
                        begin
                            res_valid   = 1'b1;
                            res_status  = STATUS_EOI;
                            res_length  = pos_inc;
                            check_limit = 1'b0;
                        end
                        else if ((stream.data_byte == MK_SOI) || is_rst)
                        begin
                            phase_next = PH_SCAN;
                        end
                        else
                        begin
                            marker_next = stream.data_byte;
                            phase_next  = PH_LENHI;
                        end
                    end
                    PH_LENHI:
                    begin
                        length_high_next = stream.data_byte;
                        phase_next       = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        if (seg_len < 16'd2)
                        begin
                            res_valid   = 1'b1;
                            res_status  = STATUS_BADLEN;
                            check_limit = 1'b0;
                        end
                        else
                        begin
                            if (marker_reg == MK_SOS)
                            begin
                                in_entropy_next = 1'b1;
                            end
                            skip_next = seg_len - 16'd2;
                            if (seg_len == 16'd2)
                            begin
                                phase_next = in_entropy_next ? PH_ENT : PH_SCAN;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 16'd1;
                        if (skip_reg == 16'd1)
                        begin
                            phase_next = in_entropy_reg ? PH_ENT : PH_SCAN;
                        end
                    end
                    PH_ENT:
                    begin
                        if (stream.data_byte == MK_PREFIX)
                        begin
                            phase_next = PH_ENTMARK;
                        end
                    end
                    PH_ENTMARK:
                    begin
                        if (stream.data_byte == MK_EOI)
                        begin
                            res_valid   = 1'b1;
                            res_status  = STATUS_EOI;
                            res_length  = pos_inc;
                            check_limit = 1'b0;
                        end
                        else if (stream.data_byte == MK_PREFIX)
                        begin
                            phase_next = PH_ENTMARK;
                        end
                        else if ((stream.data_byte == MK_STUFF) || is_rst)
                        begin
                            phase_next = PH_ENT;
                        end
                        else
                        begin
                            marker_next = stream.data_byte;
                            phase_next  = PH_LENHI;
                        end
                    end
                    default:
                    begin
                        check_limit = 1'b0;
                    end
                endcase
                if (check_limit && (pos_inc >= byte_limit_reg))
                begin
                    res_valid  = 1'b1;
                    res_status = STATUS_LIMIT;
                end
            end
            if (res_valid)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    assign out_taken = !out_valid_reg || report.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_limit_reg  <= BYTE_LIMIT_RESET;
            phase_reg       <= PH_IDLE;
            byte_pos_reg    <= 32'd0;
            skip_reg        <= 16'd0;
            length_high_reg <= 8'd0;
            marker_reg      <= 8'd0;
            in_entropy_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[APB_ADDR_W-1] == REG_BYTE_LIMIT))
            begin
                byte_limit_reg <= pwdata;
            end
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            skip_reg        <= skip_next;
            length_high_reg <= length_high_next;
            marker_reg      <= marker_next;
            in_entropy_reg  <= in_entropy_next;
            if (out_taken)
            begin
                out_valid_reg  <= skid_valid_reg || res_valid;
                skid_valid_reg <= 1'b0;
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_taken)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg <= skid_status_reg;
                out_length_reg <= skid_length_reg;
            end
            else
            begin
                out_status_reg <= res_status;
                out_length_reg <= res_length;
            end
        end
        else if (res_valid)
        begin
            skid_status_reg <= res_status;
            skid_length_reg <= res_length;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.status       = out_status_reg;
    assign report.total_length = out_length_reg;

    assign report_stall = out_valid_reg && !report.ready;
    assign out_failed   = out_valid_reg && (out_status_reg != STATUS_EOI);

    `JMLS_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `JMLS_ASSERT_NEXT(a_skid_fill, res_valid && report_stall, skid_valid_reg, "report lost")
    `JMLS_ASSERT_NEXT(a_result_ends_scan, res_valid, phase_reg == PH_DONE, "scan not ended")
    `JMLS_ASSERT_SAME(a_fail_length_zero, out_failed, out_length_reg == 32'd0, "length on failure")

endmodule

`default_nettype wire

/* tb/sv/jmls_scan_checker.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner checker
// Runs its own scanner over every accepted stream byte, queues the report that
// each byte should raise, and compares every accepted report with the oldest
// one queued. Writes to the byte limit are followed from the register port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmls_scan_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [jmls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    jmls_byte_if                                 stream,
    jmls_result_if                               report,
    output int unsigned                          mismatches,
    output int unsigned                          reports_due
);

    import jmls_pkg::*;

    localparam logic [APB_ADDR_W-1:0] BYTE_LIMIT_ADDR = APB_ADDR_W'(4 * REG_BYTE_LIMIT);

    typedef struct packed {
        status_t     status;
        logic [31:0] total_length;
    } scan_result_t;

    logic [31:0]  scan_limit;
    phase_t       phase;
    logic [31:0]  byte_count;
    logic [15:0]  skip_left;
    logic [7:0]   length_msb;
    logic [7:0]   marker;
    logic         in_scan_data;
    int unsigned  fail_total;
    scan_result_t pending_results[$];

    function automatic logic is_restart_marker(input logic [7:0] code);
        return code >= MK_RST_LO && code <= MK_RST_HI;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_total++;
    endtask

    task automatic advance_scanner(input logic [7:0] value, input logic restart);
        logic [15:0] seg_len;
        logic        done;
        status_t     outcome;
        done    = 1'b0;
        outcome = STATUS_EOI;
        if (restart)
        begin
            byte_count   = 32'd1;
            skip_left    = '0;
            length_msb   = '0;
            marker       = '0;
            in_scan_data = 1'b0;
            phase        = PH_SOI2;
            if (value != MK_PREFIX)
            begin
                done    = 1'b1;
                outcome = STATUS_NOSOI;
            end
        end
        else if (phase != PH_IDLE && phase != PH_DONE)
        begin
            byte_count = byte_count + 32'd1;
            case (phase)
                PH_SOI2:
                begin
                    if (value == MK_SOI)
                        phase = PH_SCAN;
                    else
                    begin
                        done    = 1'b1;
                        outcome = STATUS_NOSOI;
                    end
                end
                PH_SCAN:
                begin
                    if (value == MK_PREFIX)
                        phase = PH_MARK;
                end
                PH_MARK:
                begin
                    if (value == MK_EOI)
                    begin
                        done    = 1'b1;
                        outcome = STATUS_EOI;
                    end
                    else if (value == MK_SOI || is_restart_marker(value))
                        phase = PH_SCAN;
                    else if (value != MK_PREFIX)
                    begin
                        marker = value;
                        phase  = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    length_msb = value;
                    phase      = PH_LENLO;
                end
                PH_LENLO:
                begin
                    seg_len = {length_msb, value};
                    if (seg_len < 16'd2)
                    begin
                        done    = 1'b1;
                        outcome = STATUS_BADLEN;
                    end
                    else
                    begin
                        if (marker == MK_SOS)
                            in_scan_data = 1'b1;
                        skip_left = seg_len - 16'd2;
                        if (skip_left == '0)
                            phase = in_scan_data ? PH_ENT : PH_SCAN;
                        else
                            phase = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == '0)
                        phase = in_scan_data ? PH_ENT : PH_SCAN;
                end
                PH_ENT:
                begin
                    if (value == MK_PREFIX)
                        phase = PH_ENTMARK;
                end
                PH_ENTMARK:
                begin
                    if (value == MK_EOI)
                    begin
                        done    = 1'b1;
                        outcome = STATUS_EOI;
                    end
                    else if (value == MK_STUFF || is_restart_marker(value))
                        phase = PH_ENT;
                    else if (value != MK_PREFIX)
                    begin
                        marker = value;
                        phase  = PH_LENHI;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (!done && phase != PH_IDLE && phase != PH_DONE && byte_count >= scan_limit)
        begin
            done    = 1'b1;
            outcome = STATUS_LIMIT;
        end
        if (done)
        begin
            phase = PH_DONE;
            pending_results.push_back(scan_result_t'{outcome,
                (outcome == STATUS_EOI) ? byte_count : 32'd0});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t wanted;
        if (!rst_n)
        begin
            scan_limit   = BYTE_LIMIT_RESET;
            phase        = PH_IDLE;
            byte_count   = '0;
            skip_left    = '0;
            length_msb   = '0;
            marker       = '0;
            in_scan_data = 1'b0;
            fail_total   = 0;
            pending_results.delete();
            mismatches  <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("report status %0d length %0d with none pending",
                        report.status, report.total_length));
                else
                begin
                    wanted = pending_results.pop_front();
                    if (report.status !== wanted.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                            report.status, wanted.status));
                    if (report.total_length !== wanted.total_length)
                        report_mismatch($sformatf("total_length %0d, predicted %0d",
                            report.total_length, wanted.total_length));
                end
            end
            if (stream.valid && stream.ready)
                advance_scanner(stream.data_byte, stream.start_req);
            if (psel && penable && pwrite && pready && paddr == BYTE_LIMIT_ADDR)
                scan_limit = pwdata;
            mismatches  <= fail_total;
            reports_due <= pending_results.size();
        end
    end

endmodule

/* tb/sv/jpeg_marker_length_scanner_tb.sv */
// ----------------------------------------------------------------------------
// JPEG marker length scanner testbench
// Feeds directed byte streams and then randomly built JPEG streams, many of
// them well formed and the rest broken or noise, through several byte limit
// settings and idling patterns; the checker beside the block judges every
// report, and the top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_marker_length_scanner_tb;

    import jmls_pkg::*;

    localparam logic [APB_ADDR_W-1:0] BYTE_LIMIT_ADDR = APB_ADDR_W'(4 * REG_BYTE_LIMIT);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR      = APB_ADDR_W'(4 * (REG_BYTE_LIMIT + 1));

    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_DHT  = 8'hC4;

    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned PHASE_BYTES  = 110;
    localparam int unsigned PHASE_FRAMES = 6;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           apb_rdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned reports_due;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned quiet_cycles = 0;
    bit          report_hold;
    logic [7:0]  frame[$];

    jmls_byte_if   stream_if ();
    jmls_result_if report_if ();

    jpeg_marker_length_scanner u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (apb_rdata),
        .pready  (pready),
        .stream  (stream_if),
        .report  (report_if)
    );

    jmls_scan_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .stream      (stream_if),
        .report      (report_if),
        .mismatches  (mismatch_count),
        .reports_due (reports_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A long hold-off is counted here, so that the sender keeps offering bytes meanwhile.
    initial
    begin
        report_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (report_hold)
            begin
                report_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                report_hold = 1'b0;
            end
            report_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (stream_if.valid && stream_if.ready) ||
            (report_if.valid && report_if.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] value, input logic restart);
        while ($urandom_range(99) < src_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= value;
        stream_if.start_req <= restart;
        @(posedge clk);
        while (!stream_if.ready) @(posedge clk);
    endtask

    task automatic send_frame(input bit noisy);
        foreach (frame[i])
            push_byte(frame[i], noisy ? 1'($urandom_range(1)) : (i == 0));
    endtask

    task automatic wait_reports_drained();
        stream_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (reports_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_marker();
        logic [7:0] code;
        if ($urandom_range(15) == 0)
            return MK_STUFF;
        code = 8'($urandom_range(8'hC0, 8'hFE));
        if (code >= MK_RST_LO && code <= MK_SOS)
            code = code + 8'h10;
        return code;
    endfunction

    task automatic add_segment(input logic [7:0] code, input int unsigned body);
        logic [15:0] seg_len;
        seg_len = 16'(body + 2);
        frame.push_back(MK_PREFIX);
        frame.push_back(code);
        frame.push_back(seg_len[15:8]);
        frame.push_back(seg_len[7:0]);
        repeat (body) frame.push_back(8'($urandom));
    endtask

    task automatic build_frame(output bit noisy);
        int unsigned kind;
        noisy = 1'b0;
        frame.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            noisy = 1'b1;
            repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
            return;
        end
        frame.push_back(MK_PREFIX);
        frame.push_back(kind < 13 ? 8'($urandom) : MK_SOI);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(5))
                0: frame.push_back(8'($urandom_range(0, 254)));
                1:
                begin
                    frame.push_back(MK_PREFIX);
                    frame.push_back(MK_PREFIX);
                    frame.push_back(MK_SOI);
                end
                2:
                begin
                    frame.push_back(MK_PREFIX);
                    frame.push_back(8'($urandom_range(MK_RST_LO, MK_RST_HI)));
                end
                default: add_segment(pick_marker(), $urandom_range(0, 3));
            endcase
        end
        if ($urandom_range(3) != 0)
        begin
            add_segment(MK_SOS, $urandom_range(0, 3));
            repeat ($urandom_range(0, 10))
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        frame.push_back(MK_PREFIX);
                        frame.push_back(MK_STUFF);
                    end
                    1:
                    begin
                        frame.push_back(MK_PREFIX);
                        frame.push_back(8'($urandom_range(MK_RST_LO, MK_RST_HI)));
                    end
                    2:
                    begin
                        frame.push_back(MK_PREFIX);
                        frame.push_back(MK_PREFIX);
                        frame.push_back(MK_STUFF);
                    end
                    3: add_segment($urandom_range(1) ? MK_SOS : pick_marker(),
                                   $urandom_range(0, 2));
                    default: frame.push_back(8'($urandom_range(0, 254)));
                endcase
            end
        end
        if (kind >= 13 && kind < 20)
        begin
            frame.push_back(MK_PREFIX);
            frame.push_back(MK_DHT);
            frame.push_back(8'h00);
            frame.push_back(8'($urandom_range(1)));
        end
        else if (kind >= 20 && kind < 25)
        begin
            frame.push_back(MK_PREFIX);
            frame.push_back(MK_DHT);
            frame.push_back(8'($urandom_range(1, 255)));
            frame.push_back(8'($urandom));
        end
        else if (kind >= 25 && kind < 30)
        begin
            repeat ($urandom_range(0, 3))
                if (frame.size() > 1)
                    void'(frame.pop_back());
        end
        else
        begin
            if ($urandom_range(3) == 0)
                frame.push_back(MK_PREFIX);
            frame.push_back(MK_PREFIX);
            frame.push_back(MK_EOI);
            repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int unsigned src_pct, input int unsigned sink_pct);
        int unsigned bytes_sent;
        int unsigned frames_sent;
        bit          noisy;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        bytes_sent    = 0;
        frames_sent   = 0;
        while (bytes_sent < PHASE_BYTES || frames_sent < PHASE_FRAMES)
        begin
            build_frame(noisy);
            send_frame(noisy);
            bytes_sent += frame.size();
            frames_sent++;
        end
        wait_reports_drained();
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        stream_if.valid     <= 1'b0;
        stream_if.data_byte <= '0;
        stream_if.start_req <= 1'b0;
        src_idle_pct  = 8;
        sink_idle_pct = 79;
        report_hold   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        frame = {8'h00};
        send_frame(1'b0);
        frame = {MK_PREFIX, 8'h7F};
        send_frame(1'b0);
        push_byte(MK_PREFIX, 1'b0);
        frame = {MK_PREFIX, MK_SOI};
        send_frame(1'b0);
        frame = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF0, 8'h00, 8'h01};
        send_frame(1'b0);
        frame = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOS, 8'h00, 8'h02, MK_PREFIX, MK_STUFF,
                 MK_PREFIX, MK_RST_HI, MK_PREFIX, MK_PREFIX, MK_EOI};
        send_frame(1'b0);
        wait_reports_drained();

        apb_write(BYTE_LIMIT_ADDR, 32'd4);
        frame = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI};
        send_frame(1'b0);
        frame = {MK_PREFIX, MK_SOI, 8'h00, 8'h00};
        send_frame(1'b0);
        wait_reports_drained();

        report_hold = 1'b1;
        repeat (10) push_byte(8'($urandom_range(0, 254)), 1'b1);
        wait_reports_drained();

        apb_write(BYTE_LIMIT_ADDR, 32'hFFFF_FFFF);
        run_random_phase(8, 79);
        apb_write(BYTE_LIMIT_ADDR, 32'($urandom_range(16, 48)));
        run_random_phase(79, 8);
        apb_write(SPARE_ADDR, $urandom);
        run_random_phase(0, 0);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* jpeg_marker_length_scanner.f */
+incdir+rtl/core
rtl/core/jmls_pkg.sv
rtl/core/jmls_byte_if.sv
rtl/core/jmls_result_if.sv
rtl/core/jpeg_marker_length_scanner.sv
tb/sv/jmls_scan_checker.sv
tb/sv/jpeg_marker_length_scanner_tb.sv
